// ----- rtl/vrpv_pkg.sv -----
package vrpv_pkg;

  // Field and register widths
  localparam int DATA_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int DATA_MAX  = 32767;
  localparam int DATA_MIN  = -32768;

  // Viewport size in pixels
  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam int SIZE_MAX      = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int SIZE_W        = $clog2(SIZE_MAX + 1);

  // Divide lanes
  localparam int LANES  = 3;
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  // Datapath widths
  localparam int ROT1_W = 19;              // after Z rotation
  localparam int ROT2_W = 20;              // after X rotation, w
  localparam int PROD_W = 37;              // projection numerators, Q.26
  localparam int MAG_W  = PROD_W - 1;      // |numerator|
  localparam int DEN_W  = ROT2_W + 1;      // 2*|w|
  localparam int NUM_W  = MAG_W + 2;       // 2*|p| + |w|
  localparam int QUO_W  = 32;              // quotient bits kept; larger saturates
  localparam int ZERO_SH = 12;             // divide-skipped normalize shift
  localparam int N0_W   = PROD_W - ZERO_SH;
  localparam int NORM_W = QUO_W + 1;
  localparam int VP_W   = NORM_W + SIZE_W + 2;

  // Fixed-point constants
  localparam int W_OFFSET  = 12288;        // 3.0 in Q.12
  localparam int ONE_Q14   = 16384;
  localparam int VP_RND    = 16384;
  localparam int VP_SH     = 15;
  localparam int DEPTH_RND = 2;
  localparam int DEPTH_SH  = 2;
  localparam int ZERO_RND  = 2048;

  // Pipeline layout
  localparam int DIV_BITS = 2;             // quotient bits per divider stage
  localparam int DIV_STG  = QUO_W / DIV_BITS;
  localparam int ST_DIV   = 8;             // first divider stage
  localparam int ST_POST  = ST_DIV + DIV_STG;
  localparam int NUM_STG  = ST_POST + 3;

  // Register reset values
  localparam int RST_ROT_Z_COS    = 16384;
  localparam int RST_ROT_Z_SIN    = 0;
  localparam int RST_ROT_X_COS    = 16384;
  localparam int RST_ROT_X_SIN    = 0;
  localparam int RST_X_PROJ_SCALE = 12288;
  localparam int RST_Y_PROJ_SCALE = 16384;
  localparam int RST_DEPTH_SCALE  = 16386;
  localparam int RST_DEPTH_OFFSET = -1638;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [ROT1_W-1:0] rot1_t;
  typedef logic signed [ROT2_W-1:0] rot2_t;
  typedef logic        [ROT2_W-1:0] wmag_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic        [MAG_W-1:0]  mag_t;
  typedef logic        [NUM_W-1:0]  num_t;
  typedef logic        [DEN_W-1:0]  den_t;
  typedef logic        [QUO_W-1:0]  quo_t;
  typedef logic signed [N0_W-1:0]   n0_t;
  typedef logic signed [NORM_W-1:0] norm_t;
  typedef logic signed [VP_W-1:0]   vp_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_Z_COS    = 3'd0,
    REG_ROT_Z_SIN    = 3'd1,
    REG_ROT_X_COS    = 3'd2,
    REG_ROT_X_SIN    = 3'd3,
    REG_X_PROJ_SCALE = 3'd4,
    REG_Y_PROJ_SCALE = 3'd5,
    REG_DEPTH_SCALE  = 3'd6,
    REG_DEPTH_OFFSET = 3'd7
  } cfg_reg_e;

  // Per-vertex info that rides along the divider
  typedef struct packed {
    logic [LANES-1:0] neg;                 // quotient sign per lane
    logic             wz;                  // w was zero
    n0_t  [LANES-1:0] n0;                  // normalized values for w == 0
  } div_side_t;

  // One restoring divide step: returns {remainder, quotient bit}
  function automatic logic [DEN_W:0] div_step(input den_t rem, input logic nb, input den_t d);
    logic [DEN_W:0] sh;
    logic [DEN_W:0] df;
    sh = {rem, nb};
    df = sh - {1'b0, d};
    if (sh >= {1'b0, d}) begin
      return {df[DEN_W-1:0], 1'b1};
    end
    return {sh[DEN_W-1:0], 1'b0};
  endfunction

  // Clamp to signed 16 bits
  function automatic data_t sat16(input vp_t v);
    if (v > vp_t'(DATA_MAX)) begin
      return data_t'(DATA_MAX);
    end
    if (v < vp_t'(DATA_MIN)) begin
      return data_t'(DATA_MIN);
    end
    return data_t'(v);
  endfunction

endpackage

// ----- rtl/vertex_rotate_project_viewport.sv -----
// Channel    | Direction | Payload
// -----------+-----------+------------------------------------------------------
// s_axis     | in        | tdata: vertex_x, vertex_y, vertex_z (16 bits each)
// m_axis     | out       | tdata: screen_x, screen_y, depth; tuser: w_zero
// cfg        | in        | cfg_index selects one of eight 16-bit registers
//
// One word per cycle sustained while m_axis_tready stays high.
// The divider takes 16 of the pipeline stages, 2 quotient bits per stage.
// rst is synchronous: clears all stage valid bits and loads register defaults.
// Each stage holds while the next one is full; empty stages fill up, so input
// is still taken during an output stall until the whole pipeline is full.
module vertex_rotate_project_viewport (
  input  logic                               clk,
  input  logic                               rst,
  // vertex_x [15:0], vertex_y [31:16], vertex_z [47:32]
  input  logic [47:0]                        s_axis_tdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // screen_x [15:0], screen_y [31:16], depth [47:32]
  output logic [47:0]                        m_axis_tdata,
  // w_zero [0]
  output logic [0:0]                         m_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_wr_en,
  input  logic [vrpv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vrpv_pkg::DATA_W-1:0]        cfg_data
);

  // Configuration registers
  vrpv_pkg::data_t rot_z_cos, rot_z_sin, rot_x_cos, rot_x_sin;
  vrpv_pkg::data_t x_proj_scale, y_proj_scale, depth_scale, depth_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_z_cos    <= vrpv_pkg::data_t'(vrpv_pkg::RST_ROT_Z_COS);
      rot_z_sin    <= vrpv_pkg::data_t'(vrpv_pkg::RST_ROT_Z_SIN);
      rot_x_cos    <= vrpv_pkg::data_t'(vrpv_pkg::RST_ROT_X_COS);
      rot_x_sin    <= vrpv_pkg::data_t'(vrpv_pkg::RST_ROT_X_SIN);
      x_proj_scale <= vrpv_pkg::data_t'(vrpv_pkg::RST_X_PROJ_SCALE);
      y_proj_scale <= vrpv_pkg::data_t'(vrpv_pkg::RST_Y_PROJ_SCALE);
      depth_scale  <= vrpv_pkg::data_t'(vrpv_pkg::RST_DEPTH_SCALE);
      depth_offset <= vrpv_pkg::data_t'(vrpv_pkg::RST_DEPTH_OFFSET);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        vrpv_pkg::REG_ROT_Z_COS:    rot_z_cos    <= vrpv_pkg::data_t'(cfg_data);
        vrpv_pkg::REG_ROT_Z_SIN:    rot_z_sin    <= vrpv_pkg::data_t'(cfg_data);
        vrpv_pkg::REG_ROT_X_COS:    rot_x_cos    <= vrpv_pkg::data_t'(cfg_data);
        vrpv_pkg::REG_ROT_X_SIN:    rot_x_sin    <= vrpv_pkg::data_t'(cfg_data);
        vrpv_pkg::REG_X_PROJ_SCALE: x_proj_scale <= vrpv_pkg::data_t'(cfg_data);
        vrpv_pkg::REG_Y_PROJ_SCALE: y_proj_scale <= vrpv_pkg::data_t'(cfg_data);
        vrpv_pkg::REG_DEPTH_SCALE:  depth_scale  <= vrpv_pkg::data_t'(cfg_data);
        vrpv_pkg::REG_DEPTH_OFFSET: depth_offset <= vrpv_pkg::data_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // Stage valid bits and the backward load-enable chain
  logic [vrpv_pkg::NUM_STG-1:0] vld;
  logic [vrpv_pkg::NUM_STG-1:0] vld_next;
  logic [vrpv_pkg::NUM_STG-1:0] en;
  logic                         in_acc;
  logic                         out_acc;

  always_comb begin
    en[vrpv_pkg::NUM_STG-1] = !vld[vrpv_pkg::NUM_STG-1] || m_axis_tready;
    for (int k = vrpv_pkg::NUM_STG - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign vld_next      = {vld[vrpv_pkg::NUM_STG-2:0], s_axis_tvalid};
  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld[vrpv_pkg::NUM_STG-1];
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < vrpv_pkg::NUM_STG; k++) begin
        if (en[k]) begin
          vld[k] <= vld_next[k];
        end
      end
    end
  end

  // Input fields
  vrpv_pkg::data_t vx_in, vy_in, vz_in;
  assign vx_in = vrpv_pkg::data_t'(s_axis_tdata[15:0]);
  assign vy_in = vrpv_pkg::data_t'(s_axis_tdata[31:16]);
  assign vz_in = vrpv_pkg::data_t'(s_axis_tdata[47:32]);

  // Stage 0: Z rotation products
  logic signed [31:0] m_xc0, m_ys0, m_xs0, m_yc0;
  vrpv_pkg::data_t    z0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m_xc0 <= 32'(vx_in) * 32'(rot_z_cos);
      m_ys0 <= 32'(vy_in) * 32'(rot_z_sin);
      m_xs0 <= 32'(vx_in) * 32'(rot_z_sin);
      m_yc0 <= 32'(vy_in) * 32'(rot_z_cos);
      z0    <= vz_in;
    end
  end

  // Stage 1: Z rotation sums, rounded back to Q.12
  logic signed [32:0] s_xr, s_yr;
  vrpv_pkg::rot1_t    xr1, yr1;
  vrpv_pkg::data_t    z1;

  assign s_xr = 33'(m_xc0) - 33'(m_ys0) + 33'sd8192;
  assign s_yr = 33'(m_xs0) + 33'(m_yc0) + 33'sd8192;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      xr1 <= vrpv_pkg::rot1_t'(s_xr[32:14]);
      yr1 <= vrpv_pkg::rot1_t'(s_yr[32:14]);
      z1  <= z0;
    end
  end

  // Stage 2: X rotation products
  logic signed [34:0] m_yc2, m_ys2;
  logic signed [31:0] m_zs2, m_zc2;
  vrpv_pkg::rot1_t    xr2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      m_yc2 <= 35'(yr1) * 35'(rot_x_cos);
      m_ys2 <= 35'(yr1) * 35'(rot_x_sin);
      m_zs2 <= 32'(z1) * 32'(rot_x_sin);
      m_zc2 <= 32'(z1) * 32'(rot_x_cos);
      xr2   <= xr1;
    end
  end

  // Stage 3: X rotation sums and translate to w
  logic signed [35:0] s_yq, s_zq;
  vrpv_pkg::rot2_t    yq, zq;
  vrpv_pkg::rot1_t    xr3;
  vrpv_pkg::rot2_t    yq3, w3;

  assign s_yq = 36'(m_yc2) - 36'(m_zs2) + 36'sd8192;
  assign s_zq = 36'(m_ys2) + 36'(m_zc2) + 36'sd8192;
  assign yq   = vrpv_pkg::rot2_t'(s_yq[33:14]);
  assign zq   = vrpv_pkg::rot2_t'(s_zq[33:14]);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      xr3 <= xr2;
      yq3 <= yq;
      w3  <= zq + vrpv_pkg::rot2_t'(vrpv_pkg::W_OFFSET);
    end
  end

  // Stage 4: projection products
  logic signed [34:0] px4;
  logic signed [35:0] py4, pzm4;
  vrpv_pkg::rot2_t    w4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      px4  <= 35'(xr3) * 35'(x_proj_scale);
      py4  <= 36'(yq3) * 36'(y_proj_scale);
      pzm4 <= 36'(w3) * 36'(depth_scale);
      w4   <= w3;
    end
  end

  // Stage 5: depth offset, zero-w check
  vrpv_pkg::prod_t [vrpv_pkg::LANES-1:0] p5;
  vrpv_pkg::rot2_t                       w5;
  logic                                  wz5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      p5[vrpv_pkg::LANE_X] <= vrpv_pkg::prod_t'(px4);
      p5[vrpv_pkg::LANE_Y] <= vrpv_pkg::prod_t'(py4);
      p5[vrpv_pkg::LANE_Z] <= vrpv_pkg::prod_t'(pzm4)
                            + (vrpv_pkg::prod_t'(depth_offset) <<< vrpv_pkg::ZERO_SH);
      w5  <= w4;
      wz5 <= (w4 == '0);
    end
  end

  // Stage 6: magnitudes, quotient signs, divide-skipped values
  vrpv_pkg::mag_t [vrpv_pkg::LANES-1:0] mag6;
  vrpv_pkg::n0_t  [vrpv_pkg::LANES-1:0] n06;
  logic           [vrpv_pkg::LANES-1:0] neg6;
  vrpv_pkg::wmag_t                      aw6;
  logic                                 wz6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int l = 0; l < vrpv_pkg::LANES; l++) begin
        mag6[l] <= p5[l][vrpv_pkg::PROD_W-1] ? vrpv_pkg::mag_t'(-p5[l])
                                             : vrpv_pkg::mag_t'(p5[l]);
        neg6[l] <= p5[l][vrpv_pkg::PROD_W-1] ^ w5[vrpv_pkg::ROT2_W-1];
        n06[l]  <= vrpv_pkg::n0_t'((p5[l] + vrpv_pkg::prod_t'(vrpv_pkg::ZERO_RND))
                                   >>> vrpv_pkg::ZERO_SH);
      end
      aw6 <= w5[vrpv_pkg::ROT2_W-1] ? vrpv_pkg::wmag_t'(-w5) : vrpv_pkg::wmag_t'(w5);
      wz6 <= wz5;
    end
  end

  // Stage 7: round-to-nearest dividend 2|p|+|w| over divisor 2|w|
  vrpv_pkg::num_t [vrpv_pkg::LANES-1:0] num7;
  vrpv_pkg::den_t                       den7;
  vrpv_pkg::div_side_t                  side7;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int l = 0; l < vrpv_pkg::LANES; l++) begin
        num7[l] <= vrpv_pkg::num_t'({mag6[l], 1'b0}) + vrpv_pkg::num_t'(aw6);
      end
      den7       <= {aw6, 1'b0};
      side7.neg  <= neg6;
      side7.wz   <= wz6;
      side7.n0   <= n06;
    end
  end

  // Divider pipeline
  vrpv_pkg::quo_t [vrpv_pkg::LANES-1:0] quo_d;
  logic           [vrpv_pkg::LANES-1:0] ovf_d;
  vrpv_pkg::div_side_t                  side_d;

  vrpv_div u_div (
    .clk      (clk),
    .en       (en[vrpv_pkg::ST_DIV +: vrpv_pkg::DIV_STG]),
    .num_in   (num7),
    .den_in   (den7),
    .side_in  (side7),
    .quo      (quo_d),
    .ovf      (ovf_d),
    .side_out (side_d)
  );

  // Post stage 0: signed normalized value, or the shifted value when w is zero
  vrpv_pkg::norm_t [vrpv_pkg::LANES-1:0] nrm_next;
  vrpv_pkg::norm_t [vrpv_pkg::LANES-1:0] nrm24;
  logic                                  wz24;

  always_comb begin
    vrpv_pkg::quo_t  qs;
    vrpv_pkg::norm_t mg;
    for (int l = 0; l < vrpv_pkg::LANES; l++) begin
      qs = ovf_d[l] ? '1 : quo_d[l];
      mg = vrpv_pkg::norm_t'({1'b0, qs});
      if (side_d.wz) begin
        nrm_next[l] = vrpv_pkg::norm_t'(side_d.n0[l]);
      end else begin
        nrm_next[l] = side_d.neg[l] ? -mg : mg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[vrpv_pkg::ST_POST]) begin
      nrm24 <= nrm_next;
      wz24  <= side_d.wz;
    end
  end

  // Post stage 1: viewport scale, depth round and clamp
  vrpv_pkg::vp_t   vx25, vy25;
  vrpv_pkg::data_t dep25;
  logic            wz25;

  always_ff @(posedge clk) begin
    if (en[vrpv_pkg::ST_POST+1]) begin
      vx25  <= (vrpv_pkg::vp_t'(nrm24[vrpv_pkg::LANE_X]) + vrpv_pkg::vp_t'(vrpv_pkg::ONE_Q14))
             * vrpv_pkg::vp_t'(vrpv_pkg::SCREEN_WIDTH);
      vy25  <= (vrpv_pkg::vp_t'(nrm24[vrpv_pkg::LANE_Y]) + vrpv_pkg::vp_t'(vrpv_pkg::ONE_Q14))
             * vrpv_pkg::vp_t'(vrpv_pkg::SCREEN_HEIGHT);
      dep25 <= vrpv_pkg::sat16((vrpv_pkg::vp_t'(nrm24[vrpv_pkg::LANE_Z])
                               + vrpv_pkg::vp_t'(vrpv_pkg::DEPTH_RND)) >>> vrpv_pkg::DEPTH_SH);
      wz25  <= wz24;
    end
  end

  // Post stage 2: pixel round and clamp, output register
  vrpv_pkg::data_t sx26, sy26, dep26;
  logic            wz26;

  always_ff @(posedge clk) begin
    if (en[vrpv_pkg::ST_POST+2]) begin
      sx26  <= vrpv_pkg::sat16((vx25 + vrpv_pkg::vp_t'(vrpv_pkg::VP_RND)) >>> vrpv_pkg::VP_SH);
      sy26  <= vrpv_pkg::sat16((vy25 + vrpv_pkg::vp_t'(vrpv_pkg::VP_RND)) >>> vrpv_pkg::VP_SH);
      dep26 <= dep25;
      wz26  <= wz25;
    end
  end

  assign m_axis_tdata = {dep26, sy26, sx26};
  assign m_axis_tuser = wz26;

  // Input only blocks when every stage holds a word
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (&vld))
    else $error("input stalled with an empty stage");

  // An accepted word lands in the first stage
  a_entry: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> vld[0])
    else $error("accepted word not captured");

  // Words in flight change only by accepted and delivered words
  a_conserve: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones(vld) == $countones($past(vld))
                     + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("word lost or duplicated in pipeline");

endmodule

// ----- rtl/vrpv_div.sv -----
module vrpv_div (
  input  logic                                    clk,
  input  logic [vrpv_pkg::DIV_STG-1:0]            en,       // per-stage load enable
  input  vrpv_pkg::num_t [vrpv_pkg::LANES-1:0]    num_in,
  input  vrpv_pkg::den_t                          den_in,
  input  vrpv_pkg::div_side_t                     side_in,
  output vrpv_pkg::quo_t [vrpv_pkg::LANES-1:0]    quo,
  output logic [vrpv_pkg::LANES-1:0]              ovf,      // quotient does not fit
  output vrpv_pkg::div_side_t                     side_out
);

  vrpv_pkg::den_t      rem  [vrpv_pkg::DIV_STG][vrpv_pkg::LANES];
  vrpv_pkg::quo_t      dq   [vrpv_pkg::DIV_STG][vrpv_pkg::LANES];
  logic                ovfs [vrpv_pkg::DIV_STG][vrpv_pkg::LANES];
  vrpv_pkg::den_t      den  [vrpv_pkg::DIV_STG];
  vrpv_pkg::div_side_t side [vrpv_pkg::DIV_STG];

  vrpv_pkg::den_t      rem_in  [vrpv_pkg::DIV_STG][vrpv_pkg::LANES];
  vrpv_pkg::quo_t      dq_in   [vrpv_pkg::DIV_STG][vrpv_pkg::LANES];
  logic                ovf_in  [vrpv_pkg::DIV_STG][vrpv_pkg::LANES];
  vrpv_pkg::den_t      den_stg [vrpv_pkg::DIV_STG];
  vrpv_pkg::div_side_t side_stg[vrpv_pkg::DIV_STG];
  vrpv_pkg::den_t      rem_next[vrpv_pkg::DIV_STG][vrpv_pkg::LANES];
  vrpv_pkg::quo_t      dq_next [vrpv_pkg::DIV_STG][vrpv_pkg::LANES];

  // Stage inputs: first stage seeds remainder with the dividend top bits
  always_comb begin
    for (int l = 0; l < vrpv_pkg::LANES; l++) begin
      rem_in[0][l] = vrpv_pkg::den_t'(num_in[l][vrpv_pkg::NUM_W-1:vrpv_pkg::QUO_W]);
      dq_in[0][l]  = num_in[l][vrpv_pkg::QUO_W-1:0];
      ovf_in[0][l] = vrpv_pkg::den_t'(num_in[l][vrpv_pkg::NUM_W-1:vrpv_pkg::QUO_W]) >= den_in;
    end
    den_stg[0]  = den_in;
    side_stg[0] = side_in;
    for (int s = 1; s < vrpv_pkg::DIV_STG; s++) begin
      for (int l = 0; l < vrpv_pkg::LANES; l++) begin
        rem_in[s][l] = rem[s-1][l];
        dq_in[s][l]  = dq[s-1][l];
        ovf_in[s][l] = ovfs[s-1][l];
      end
      den_stg[s]  = den[s-1];
      side_stg[s] = side[s-1];
    end
  end

  // DIV_BITS restoring steps per stage; dividend bits shift out, quotient bits shift in
  always_comb begin
    vrpv_pkg::den_t           r;
    vrpv_pkg::quo_t           q;
    logic [vrpv_pkg::DEN_W:0] st;
    for (int s = 0; s < vrpv_pkg::DIV_STG; s++) begin
      for (int l = 0; l < vrpv_pkg::LANES; l++) begin
        r = rem_in[s][l];
        q = dq_in[s][l];
        for (int b = 0; b < vrpv_pkg::DIV_BITS; b++) begin
          st = vrpv_pkg::div_step(r, q[vrpv_pkg::QUO_W-1], den_stg[s]);
          r  = st[vrpv_pkg::DEN_W:1];
          q  = {q[vrpv_pkg::QUO_W-2:0], st[0]};
        end
        rem_next[s][l] = r;
        dq_next[s][l]  = q;
      end
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    for (int s = 0; s < vrpv_pkg::DIV_STG; s++) begin
      if (en[s]) begin
        for (int l = 0; l < vrpv_pkg::LANES; l++) begin
          rem[s][l]  <= rem_next[s][l];
          dq[s][l]   <= dq_next[s][l];
          ovfs[s][l] <= ovf_in[s][l];
        end
        den[s]  <= den_stg[s];
        side[s] <= side_stg[s];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < vrpv_pkg::LANES; l++) begin
      quo[l] = dq[vrpv_pkg::DIV_STG-1][l];
      ovf[l] = ovfs[vrpv_pkg::DIV_STG-1][l];
    end
    side_out = side[vrpv_pkg::DIV_STG-1];
  end

endmodule
